// ===== src/fmpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter package
// Widths, reset values, register indexes and shared types of the flow meter.
// ----------------------------------------------------------------------------
package fmpw_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  localparam int CAL_W     = 24;
  localparam int WIN_W     = 16;
  localparam int THR_W     = 16;
  localparam int ELAPSED_W = 17;
  localparam int VOL_W     = 32;
  localparam int RATE_W    = 33;
  localparam int TOTAL_W   = 48;

  localparam int PROD_W = COUNT_BITS + CAL_W;
  localparam int CMP_W  = (PROD_W > THR_W + FRACTION_BITS) ? PROD_W : THR_W + FRACTION_BITS;

  // Rate is volume times one thousand over elapsed milliseconds.
  localparam int SCALE_W   = 10;
  localparam int DVD_W     = VOL_W + SCALE_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [SCALE_W-1:0]   SCALE       = SCALE_W'(1000);
  localparam logic [VOL_W-1:0]     VOL_MAX     = '1;
  localparam logic [RATE_W-1:0]    RATE_MAX    = '1;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [CAL_W-1:0] CAL_RESET       = CAL_W'(15604);
  localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(500);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(3);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = VOL_W + RATE_W + TOTAL_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CAL_W;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  typedef struct packed {
    logic                  close;
    logic [COUNT_BITS-1:0] pulse_count;
    logic [ELAPSED_W-1:0]  elapsed;
  } win_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/fmpw_window_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter window counter
// Saturating pulse and millisecond counters with the window-close test.
// ----------------------------------------------------------------------------
module fmpw_window_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          pulse_edge,
  input  logic                          ms_tick,
  input  logic [fmpw_pkg::WIN_W-1:0]    window_ms,
  output fmpw_pkg::win_status_t         status
);

  logic [fmpw_pkg::COUNT_BITS-1:0] pulse_count;
  logic [fmpw_pkg::ELAPSED_W-1:0]  elapsed_ms;
  logic [fmpw_pkg::COUNT_BITS-1:0] pulse_count_next;
  logic [fmpw_pkg::ELAPSED_W-1:0]  elapsed_ms_next;

  // The pulse is counted before the tick, and both before the window test.
  always_comb begin
    pulse_count_next = pulse_count;
    elapsed_ms_next  = elapsed_ms;
    if (pulse_edge && (pulse_count != fmpw_pkg::COUNT_MAX)) begin
      pulse_count_next = pulse_count + 1'b1;
    end
    if (ms_tick && (elapsed_ms != fmpw_pkg::ELAPSED_MAX)) begin
      elapsed_ms_next = elapsed_ms + 1'b1;
    end
  end

  assign status.pulse_count = pulse_count_next;
  assign status.elapsed     = elapsed_ms_next;
  assign status.close       = elapsed_ms_next > fmpw_pkg::ELAPSED_W'(window_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      elapsed_ms  <= '0;
    end else if (accept) begin
      if (status.close) begin
        pulse_count <= '0;
        elapsed_ms  <= '0;
      end else begin
        pulse_count <= pulse_count_next;
        elapsed_ms  <= elapsed_ms_next;
      end
    end
  end

endmodule

// ===== src/fmpw_div_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter divider
// Restoring shift-and-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmpw_div_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [fmpw_pkg::DVD_W-1:0]        dividend,
  input  logic [fmpw_pkg::ELAPSED_W-1:0]    divisor,
  output logic [fmpw_pkg::DVD_W-1:0]        quotient,
  output fmpw_pkg::div_status_t             status
);

  logic [fmpw_pkg::ELAPSED_W-1:0]   rem;
  logic [fmpw_pkg::ELAPSED_W-1:0]   dvs;
  logic [fmpw_pkg::DIV_CNT_W-1:0]   cnt;
  logic                             busy;
  logic                             done;
  logic [fmpw_pkg::ELAPSED_W:0]     shifted;
  logic                             fits;

  // The remainder stays below the divisor, so it fits in the divisor's width
  // and one extra bit holds the shift.
  assign shifted = {rem, quotient[fmpw_pkg::DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= fmpw_pkg::DIV_CNT_W'(fmpw_pkg::DVD_W - 1);
    end else if (busy) begin
      rem      <= fmpw_pkg::ELAPSED_W'(fits ? (shifted - {1'b0, dvs}) : shifted);
      quotient <= {quotient[fmpw_pkg::DVD_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== src/flow_meter_pulse_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter with pulse window
// Counts sensor pulses and milliseconds, and at each window close reports the
// window volume, the flow rate, the running total and a flowing flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    pulse edge and millisecond tick
//  m_*       out        m_tvalid/m_tready    window result
//  cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// An input transaction that leaves the window open leaves s_tready high, and
// the next one may follow straight after. A transaction that closes the window
// starts a computation in which the divider produces one quotient bit per
// cycle over the 42-bit scaled volume; s_tready stays low until the result is
// in the output register. That register lets the next input transaction in
// while m_tready is low; a further closing transaction waits at the end of its
// computation until the output register is free. Reset is synchronous and
// returns the counters, the running total and the registers to their reset
// values. The configuration channel is always ready.
// ----------------------------------------------------------------------------
module flow_meter_pulse_window (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: pulse_edge [0], ms_tick [1], zero fill [7:2]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [fmpw_pkg::IN_DATA_W-1:0]       s_tdata,
  // m_tdata: window_volume [31:0], flow_rate [64:32], total_volume [112:65],
  //          water_flowing [113], zero fill [119:114]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [fmpw_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fmpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmpw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // One-hot sequencer for a closing window.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_START = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [fmpw_pkg::CAL_W-1:0] cal_factor;
  logic [fmpw_pkg::WIN_W-1:0] window_ms;
  logic [fmpw_pkg::THR_W-1:0] flow_threshold_ml;

  fmpw_pkg::win_status_t win_status;
  fmpw_pkg::div_status_t div_status;

  logic                              s_accept;
  logic                              out_free;
  logic [fmpw_pkg::COUNT_BITS-1:0]   cap_count;
  logic [fmpw_pkg::ELAPSED_W-1:0]    cap_elapsed;
  logic [fmpw_pkg::PROD_W-1:0]       product;
  logic [fmpw_pkg::VOL_W-1:0]        vol;
  logic [fmpw_pkg::VOL_W-1:0]        vol_sat;
  logic                              flowing;
  logic                              flowing_next;
  logic [fmpw_pkg::TOTAL_W-1:0]      volume_total;
  logic [fmpw_pkg::TOTAL_W:0]        total_sum;
  logic [fmpw_pkg::DVD_W-1:0]        dividend;
  logic [fmpw_pkg::DVD_W-1:0]        quotient;
  logic [fmpw_pkg::RATE_W-1:0]       rate_sat;

  assign s_tready  = state == ST_IDLE;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_factor        <= fmpw_pkg::CAL_RESET;
      window_ms         <= fmpw_pkg::WINDOW_RESET;
      flow_threshold_ml <= fmpw_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmpw_pkg::REG_CAL_FACTOR: cal_factor        <= cfg_data;
        fmpw_pkg::REG_WINDOW_MS:  window_ms         <= fmpw_pkg::WIN_W'(cfg_data);
        fmpw_pkg::REG_THRESHOLD:  flow_threshold_ml <= fmpw_pkg::THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  fmpw_window_counter u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_accept),
    .pulse_edge (s_tdata[0]),
    .ms_tick    (s_tdata[1]),
    .window_ms  (window_ms),
    .status     (win_status)
  );

  // The scaled volume is formed as the divider is started.
  assign dividend = fmpw_pkg::DVD_W'(vol) * fmpw_pkg::DVD_W'(fmpw_pkg::SCALE);

  fmpw_div_unit u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (dividend),
    .divisor  (cap_elapsed),
    .quotient (quotient),
    .status   (div_status)
  );

  // Volume saturates, while the flag compares the full product.
  assign vol_sat = (product > fmpw_pkg::PROD_W'(fmpw_pkg::VOL_MAX)) ?
                   fmpw_pkg::VOL_MAX : fmpw_pkg::VOL_W'(product);
  assign flowing_next = fmpw_pkg::CMP_W'(product) >
                        fmpw_pkg::CMP_W'({flow_threshold_ml, {fmpw_pkg::FRACTION_BITS{1'b0}}});
  assign total_sum = (fmpw_pkg::TOTAL_W + 1)'(volume_total) +
                     (fmpw_pkg::TOTAL_W + 1)'(vol_sat);
  assign rate_sat = (quotient > fmpw_pkg::DVD_W'(fmpw_pkg::RATE_MAX)) ?
                    fmpw_pkg::RATE_MAX : fmpw_pkg::RATE_W'(quotient);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_accept && win_status.close) state_next = ST_MUL;
      ST_MUL:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_status.done) state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      volume_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        volume_total <= total_sum[fmpw_pkg::TOTAL_W] ?
                        fmpw_pkg::TOTAL_MAX : total_sum[fmpw_pkg::TOTAL_W-1:0];
      end
      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_accept && win_status.close) begin
      cap_count   <= win_status.pulse_count;
      cap_elapsed <= win_status.elapsed;
    end
    if (state == ST_MUL) begin
      product <= fmpw_pkg::PROD_W'(cap_count) * fmpw_pkg::PROD_W'(cal_factor);
    end
    if (state == ST_LOAD) begin
      vol     <= vol_sat;
      flowing <= flowing_next;
    end
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= fmpw_pkg::OUT_DATA_W'({flowing, volume_total, rate_sat, vol});
    end
  end

endmodule

// ===== src/fmpw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter port checker
// Checks the flow meter's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module fmpw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [fmpw_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // A new result is only loaded while input transactions are held off.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while input was open");

  // Flow is only reported for a window with some volume in it.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[fmpw_pkg::OUT_BITS-1] ||
                 (m_tdata[fmpw_pkg::VOL_W-1:0] != '0))
    else $error("flowing flag with empty window");

endmodule

bind flow_meter_pulse_window fmpw_checker u_fmpw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow meter pulse window testbench
// Drives pulse edge and millisecond tick transactions into the flow meter,
// predicts every window close in the testbench itself and compares each
// result transaction field by field. The run covers the reset settings,
// directed corner cases, volume and rate saturation, a long output hold-off and
// randomised register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
  import fmpw_pkg::*;

  // Clock period is 20 ns. Quiet periods are a little longer than the
  // computation of a closing transaction.
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 400;
  localparam longint      LIMIT_CYCLES  = 2000000;
  // Index 3 is not decoded by the block; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One window result, laid out as in m_tdata with window_volume lowest.
  typedef struct packed {
    logic               water_flowing;
    logic [TOTAL_W-1:0] total_volume;
    logic [RATE_W-1:0]  flow_rate;
    logic [VOL_W-1:0]   window_volume;
  } window_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  flow_meter_pulse_window dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted state of the meter: its registers, its two counters and the
  // running total. These follow the block transaction by transaction.
  // --------------------------------------------------------------------------
  logic [CAL_W-1:0]      cal_q16;
  logic [WIN_W-1:0]      window_len;
  logic [THR_W-1:0]      threshold_ml;
  logic [COUNT_BITS-1:0] pulses_seen;
  logic [ELAPSED_W-1:0]  ms_seen;
  logic [TOTAL_W-1:0]    running_total;

  window_result_t expected_windows[$];
  int             mismatches = 0;
  longint         cycle_count = 0;

  // Stimulus knobs, set by the test tasks.
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int burst_left   = 0;

  // The receiver serves a hold-off whenever hold_asked moves ahead of
  // hold_served; each counter has one writer only.
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int rx_run      = 0;
  bit rx_open     = 1'b1;

  // Applies one input transaction to the predicted state. Returns 1 and
  // fills res when the window closes. The pulse is counted before the tick,
  // so a pulse in the closing transaction belongs to the closing window.
  function automatic bit meter_step(input logic pulse, input logic tick,
                                    output window_result_t res);
    logic [63:0] product;
    logic [63:0] vol;
    logic [63:0] rate;
    logic [63:0] sum;
    res = '0;
    if (pulse && pulses_seen != COUNT_MAX) pulses_seen = pulses_seen + 1'b1;
    if (tick && ms_seen != ELAPSED_MAX) ms_seen = ms_seen + 1'b1;
    if (64'(ms_seen) <= 64'(window_len)) return 1'b0;
    product = 64'(pulses_seen) * 64'(cal_q16);
    vol     = (product > 64'(VOL_MAX)) ? 64'(VOL_MAX) : product;
    // The elapsed count is at least one here, so the divide is safe.
    rate    = (vol * 64'd1000) / 64'(ms_seen);
    if (rate > 64'(RATE_MAX)) rate = 64'(RATE_MAX);
    sum     = 64'(running_total) + vol;
    if (sum > 64'(TOTAL_MAX)) sum = 64'(TOTAL_MAX);
    running_total     = sum[TOTAL_W-1:0];
    res.window_volume = vol[VOL_W-1:0];
    res.flow_rate     = rate[RATE_W-1:0];
    res.total_volume  = sum[TOTAL_W-1:0];
    // The flag looks at the product before it is clipped to 32 bits.
    res.water_flowing = product > (64'(threshold_ml) << FRACTION_BITS);
    pulses_seen = '0;
    ms_seen     = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, so the values seen are
  // those the block saw. A result is checked before the input transaction of
  // the same edge is predicted; it can never belong to that transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      cal_q16       = CAL_RESET;
      window_len    = WINDOW_RESET;
      threshold_ml  = THRESHOLD_RESET;
      pulses_seen   = '0;
      ms_seen       = '0;
      running_total = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = window_result_t'(m_tdata[OUT_BITS-1:0]);
        if (expected_windows.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transaction with none expected, actual %0h",
                   $time, got);
        end else begin
          want = expected_windows.pop_front();
          check_field("window_volume", 64'(want.window_volume), 64'(got.window_volume));
          check_field("flow_rate", 64'(want.flow_rate), 64'(got.flow_rate));
          check_field("total_volume", 64'(want.total_volume), 64'(got.total_volume));
          check_field("water_flowing", 64'(want.water_flowing), 64'(got.water_flowing));
        end
      end
      if (s_tvalid && s_tready) begin
        if (meter_step(s_tdata[0], s_tdata[1], want)) expected_windows.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAL_FACTOR: cal_q16      = cfg_data[CAL_W-1:0];
          REG_WINDOW_MS:  window_len   = cfg_data[WIN_W-1:0];
          REG_THRESHOLD:  threshold_ml = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: alternating runs of ready and stall of random lengths, a long
  // hold-off on request, or always ready when stalls are switched off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_open = !rx_open;
        rx_run  = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 7);
      end
      rx_run--;
      m_tready <= rx_open;
    end
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Sends one pulse/tick transaction. With gaps enabled the sender works in
  // bursts and drops s_tvalid for a random number of cycles between them;
  // otherwise s_tvalid stays high from one transaction to the next.
  task automatic send_item(input logic pulse, input logic tick);
    int unsigned gap;
    if (tx_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({tick, pulse});
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops the sender and waits until every predicted result has been taken,
  // then lets the block run quiet for a while so no computation is in flight.
  // The first edge lets the monitor record the last transaction sent.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; cfg_valid is dropped for a cycle afterwards so that
  // back-to-back writes never raise and lower it in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at their reset values: a 500 ms window closes on the 501st
  // tick. One full window with random pulses.
  task automatic test_reset_values();
    repeat (501) send_item(1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Short hand-made sequences: idle transactions, a pulse in the closing
  // transaction, the threshold on both sides, zero calibration, a window of
  // zero and of one, upper data bits that must be masked, and a write to an
  // unused index.
  task automatic test_directed();
    settle();
    write_reg(REG_CAL_FACTOR, 24'h010000);        // exactly 1 mL per pulse
    write_reg(REG_WINDOW_MS, 24'h000000);         // closes on the first tick
    write_reg(REG_THRESHOLD, 24'h000002);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);                        // 3 mL, above the threshold
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);                        // 2 mL, equal, not flowing
    settle();
    write_reg(REG_WINDOW_MS, 24'hFF0001);         // upper byte must be ignored
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    settle();
    write_reg(REG_CAL_FACTOR, 24'h000000);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b1);
    settle();
    write_reg(REG_CAL_FACTOR, 24'h000001);
    write_reg(REG_THRESHOLD, 24'hFF0000);         // threshold of zero
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);
    settle();
    write_reg(REG_SPARE, 24'hFFFFFF);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b1);
  endtask

  // Largest calibration with a window of zero: pulse counts either side of
  // the 32-bit volume limit. The flow rate clips at its top in each case.
  task automatic test_volume_overflow();
    int counts[2] = '{256, 257};
    settle();
    write_reg(REG_CAL_FACTOR, 24'hFFFFFF);
    write_reg(REG_WINDOW_MS, 24'h000000);
    write_reg(REG_THRESHOLD, 24'h00FFFF);
    foreach (counts[k]) begin
      repeat (counts[k]) send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b1);
    end
  endtask

  // Every transaction closes a window while the receiver holds off for a
  // long stretch, so the output register and the pending computation fill up
  // and s_tready must stay low. Afterwards the sender waits for a full drain.
  task automatic test_backpressure();
    settle();
    write_reg(REG_CAL_FACTOR, CAL_W'($urandom));
    write_reg(REG_WINDOW_MS, 24'h000000);
    tx_gaps_on = 1'b0;
    @(negedge clk) hold_asked++;
    @(posedge clk);
    repeat (40) send_item(1'($urandom_range(0, 1)), 1'b1);
    settle();
    tx_gaps_on = 1'b1;
    repeat (20) send_item(1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Random phases, each with fresh register values and its own pulse and
  // tick densities. Windows are kept short so results come often; some
  // phases run without sender gaps or receiver stalls.
  task automatic test_random();
    logic [CAL_W-1:0] cal;
    logic [WIN_W-1:0] win;
    logic [THR_W-1:0] thr;
    int unsigned      tick_pct;
    int unsigned      pulse_pct;
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       cal = '0;
        1:       cal = '1;
        default: cal = CAL_W'($urandom);
      endcase
      win = ($urandom_range(0, 4) == 0) ? WIN_W'($urandom_range(13, 120))
                                        : WIN_W'($urandom_range(0, 12));
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = THR_W'($urandom_range(0, 600));
      endcase
      write_reg(REG_CAL_FACTOR, cal);
      write_reg(REG_WINDOW_MS, {8'($urandom), win});
      write_reg(REG_THRESHOLD, {8'($urandom), thr});
      tx_gaps_on   = (phase % 4) != 3;
      rx_stalls_on = (phase % 4) != 2;
      tick_pct     = $urandom_range(20, 90);
      pulse_pct    = $urandom_range(10, 95);
      repeat (60) send_item($urandom_range(0, 99) < pulse_pct,
                            $urandom_range(0, 99) < tick_pct);
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run. Note that the running total cannot be driven to its
  // 48-bit limit within a run of sensible length, nor can the pulse counter,
  // which needs 65535 pulses in one window, and the elapsed counter cannot
  // reach its top, since the window register closes the window long before.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_volume_overflow();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
